// ===== hdl/bepr_pkg.sv =====
// shared types and constants for the braille packet responder
`default_nettype none
package bepr_pkg;

    localparam int MAX_CELLS_DEF = 320;
    localparam int STEP_QDEPTH = 4;
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] REQ_DISPLAY = 8'h01;
    localparam logic [7:0] REQ_VERSION = 8'h05;
    localparam logic [7:0] REQ_KEYS = 8'h08;
    localparam logic [7:0] REQ_MODE = 8'h12;
    localparam logic [7:0] REQ_PROTO = 8'h15;
    localparam logic [7:0] REQ_IDENT = 8'h84;
    localparam logic [7:0] REQ_SERIAL = 8'h8A;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_CELL = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    // reply types queued to the back end
    localparam logic [2:0] JOB_NONE = 3'd0;
    localparam logic [2:0] JOB_COUNT = 3'd1;
    localparam logic [2:0] JOB_VERSION = 3'd2;
    localparam logic [2:0] JOB_SERIAL = 3'd3;
    localparam logic [2:0] JOB_IDENT = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [8:0] cell_index;
        logic [8:0] cursor_position;
        logic       last;
    } out_item_t;

    // one classified step: up to two jobs in order (the reply to a latched request, then a count or request reply)
    typedef struct packed {
        logic [2:0] job_a;
        logic [2:0] job_b;
        logic       cell_ev;
        logic [7:0] cell_val;
        logic [8:0] cell_idx;
        logic       frame_ev;
        logic [8:0] frame_cur;
        logic [7:0] cnt_byte;
        logic [7:0] col_tens;
        logic [7:0] col_ones;
    } step_t;

    // identity payload byte k (k = 0..16), tens/ones are the column digits
    function automatic logic [7:0] ident_byte(input logic [4:0] k,
                                              input logic [7:0] tens,
                                              input logic [7:0] ones);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            5'd0: r = 8'h84;
            5'd1: r = 8'h42;
            5'd2: r = 8'h61;
            5'd3: r = 8'h75;
            5'd4: r = 8'h6D;
            5'd5: r = 8'h20;
            5'd6: r = 8'h56;
            5'd7: r = 8'h61;
            5'd8: r = 8'h72;
            5'd9: r = 8'h69;
            5'd10: r = 8'h6F;
            5'd11: r = tens;
            5'd12: r = ones;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/braille_escape_packet_responder.sv =====
// top level of the escape-framed braille packet responder
//
//  channel | dir | handshake                | payload
//  in      | in  | in_valid / in_ready      | in_item   (command, data_byte)
//  out     | out | out_valid / out_ready    | out_item  (kind, value, cell_index, ...)
//  cfg     | in  | cfg_write                | cfg_index, cfg_data
//
// one input transfer per cycle while in_ready is high; the front end parses it in that cycle
// and pushes one step record into a short queue
// the back end emits one result transfer per cycle while out_ready allows, up to 18 per step
// reset clears parser, timer, queue and output valid flag; config to reset values
// in_ready drops only when the queue is near full, during long reply bursts
`default_nettype none
module braille_escape_packet_responder #(
    parameter int MAX_CELLS = bepr_pkg::MAX_CELLS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bepr_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bepr_pkg::out_item_t      out_item,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    bepr_pkg::step_t step;
    logic in_fire;
    logic space;

    assign in_ready = space;
    assign in_fire = in_valid && in_ready;

    // parser and timer
    bepr_front #(.MAX_CELLS(MAX_CELLS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_fire(in_fire), .in_item(in_item), .step(step)
    );

    // result sequencer
    bepr_back #(.QDEPTH(bepr_pkg::STEP_QDEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .push(in_fire), .step(step), .space(space),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

endmodule
`default_nettype wire

// ===== hdl/bepr_front.sv =====
// front end: packet parser, timer and classification of each input
`default_nettype none
module bepr_front #(
    parameter int MAX_CELLS = bepr_pkg::MAX_CELLS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_fire,
    input  wire bepr_pkg::in_item_t in_item,
    output bepr_pkg::step_t        step
);
    localparam int CW = $clog2(MAX_CELLS + 1);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_REQ     = 6'b000010,
        PH_CELLS   = 6'b000100,
        PH_ARGS    = 6'b001000,
        PH_SKIP    = 6'b010000,
        PH_LATCHED = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  req_reg, req_next;
    logic        esc_reg, esc_next;
    logic [1:0]  args_reg, args_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic        armed_reg, armed_next;
    logic [15:0] tcount_reg, tcount_next;
    logic [6:0]  cols_reg, cols_next;
    logic [2:0]  rows_reg, rows_next;
    logic [15:0] tout_reg;
    logic [CW-1:0] total_reg;
    logic [7:0]  tens_reg, ones_reg;

    // cell total and column digits, registered together with each config write
    logic [9:0] prod;
    logic [3:0] tens_c;
    logic [6:0] ones_c;
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_write && cfg_index == bepr_pkg::CFG_COLUMNS)
            cols_next = cfg_data[6:0];
        if (cfg_write && cfg_index == bepr_pkg::CFG_ROWS)
            rows_next = cfg_data[2:0];
        prod = 10'(cols_next) * 10'(rows_next);
        tens_c = 4'((15'(cols_next) * 15'd205) >> 11);
        ones_c = cols_next - 7'(tens_c) * 7'd10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd40;
            rows_reg <= 3'd1;
            tout_reg <= 16'd1000;
            total_reg <= CW'(40 > MAX_CELLS ? MAX_CELLS : 40);
            tens_reg <= 8'h34;
            ones_reg <= 8'h30;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            if (cfg_write && cfg_index == bepr_pkg::CFG_TIMEOUT)
                tout_reg <= cfg_data;
            total_reg <= (32'(prod) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(prod);
            tens_reg <= 8'h30 + 8'(tens_c);
            ones_reg <= 8'h30 + 8'(ones_c);
        end
    end

    // per-step combinational parse
    always_comb
    begin
        logic [7:0] b;
        logic       data_in;
        logic       disp;
        logic [7:0] dreq;
        logic [CW-1:0] inc;
        logic [2:0] job;
        b = in_item.data_byte;
        data_in = 1'b0;
        disp = 1'b0;
        dreq = b;
        inc = '0;
        job = bepr_pkg::JOB_NONE;
        phase_next = phase_reg;
        req_next = req_reg;
        esc_next = esc_reg;
        args_next = args_reg;
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        armed_next = armed_reg;
        tcount_next = tcount_reg;
        step = '0;
        step.cnt_byte = 8'(total_reg);
        step.col_tens = tens_reg;
        step.col_ones = ones_reg;

        // latched request from a break is acted on first
        if (phase_reg == PH_LATCHED)
        begin
            esc_next = 1'b0;
            phase_next = PH_HUNT;
            case (req_reg)
                bepr_pkg::REQ_DISPLAY:
                begin
                    cnt_next = '0;
                    cur_next = '0;
                    if (total_reg == '0)
                    begin
                        armed_next = 1'b0;
                        step.frame_ev = 1'b1;
                    end
                    else
                    begin
                        armed_next = 1'b1;
                        tcount_next = tout_reg;
                        phase_next = PH_CELLS;
                    end
                end
                bepr_pkg::REQ_MODE:
                begin
                    args_next = 2'd2;
                    phase_next = PH_ARGS;
                end
                bepr_pkg::REQ_PROTO:
                begin
                    args_next = 2'd1;
                    phase_next = PH_ARGS;
                end
                bepr_pkg::REQ_KEYS:   ;
                bepr_pkg::REQ_VERSION: step.job_a = bepr_pkg::JOB_VERSION;
                bepr_pkg::REQ_SERIAL:  step.job_a = bepr_pkg::JOB_SERIAL;
                bepr_pkg::REQ_IDENT:   step.job_a = bepr_pkg::JOB_IDENT;
                default: phase_next = PH_SKIP;
            endcase
        end

        if (in_item.command)
        begin
            if (armed_next)
            begin
                if (tcount_next <= 16'd1)
                begin
                    armed_next = 1'b0;
                    tcount_next = '0;
                    job = bepr_pkg::JOB_COUNT;
                end
                else
                    tcount_next = tcount_next - 16'd1;
            end
        end
        else
        begin
            case (phase_next)
                PH_HUNT, PH_SKIP:
                    if (b == bepr_pkg::ESC_BYTE)
                    begin
                        phase_next = PH_REQ;
                        esc_next = 1'b0;
                    end
                PH_REQ, PH_CELLS, PH_ARGS:
                    if (esc_next)
                    begin
                        esc_next = 1'b0;
                        if (b == bepr_pkg::ESC_BYTE)
                            data_in = 1'b1;
                        else if (armed_next)
                        begin
                            armed_next = 1'b0;
                            job = bepr_pkg::JOB_COUNT;
                            req_next = b;
                            phase_next = PH_LATCHED;
                        end
                        else
                            disp = 1'b1;
                    end
                    else if (b == bepr_pkg::ESC_BYTE)
                        esc_next = 1'b1;
                    else
                        data_in = 1'b1;
                default: phase_next = PH_HUNT;
            endcase

            if (data_in)
            begin
                if (phase_next == PH_REQ)
                    disp = 1'b1;
                else if (phase_next == PH_CELLS)
                begin
                    step.cell_ev = 1'b1;
                    step.cell_val = b;
                    step.cell_idx = 9'(cnt_next);
                    inc = cnt_next + CW'(1);
                    if (b[7:6] == 2'b11)
                        cur_next = inc;
                    cnt_next = inc;
                    if (inc >= total_reg)
                    begin
                        step.frame_ev = 1'b1;
                        armed_next = 1'b0;
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    if (args_next != 2'd0)
                        args_next = args_next - 2'd1;
                    if (args_next == 2'd0)
                        phase_next = PH_HUNT;
                end
            end

            if (disp)
            begin
                req_next = dreq;
                esc_next = 1'b0;
                phase_next = PH_HUNT;
                case (dreq)
                    bepr_pkg::REQ_DISPLAY:
                    begin
                        cnt_next = '0;
                        cur_next = '0;
                        if (total_reg == '0)
                        begin
                            armed_next = 1'b0;
                            step.frame_ev = 1'b1;
                        end
                        else
                        begin
                            armed_next = 1'b1;
                            tcount_next = tout_reg;
                            phase_next = PH_CELLS;
                        end
                    end
                    bepr_pkg::REQ_MODE:
                    begin
                        args_next = 2'd2;
                        phase_next = PH_ARGS;
                    end
                    bepr_pkg::REQ_PROTO:
                    begin
                        args_next = 2'd1;
                        phase_next = PH_ARGS;
                    end
                    bepr_pkg::REQ_KEYS:   ;
                    bepr_pkg::REQ_VERSION: job = bepr_pkg::JOB_VERSION;
                    bepr_pkg::REQ_SERIAL:  job = bepr_pkg::JOB_SERIAL;
                    bepr_pkg::REQ_IDENT:   job = bepr_pkg::JOB_IDENT;
                    default: phase_next = PH_SKIP;
                endcase
            end
        end
        step.frame_cur = 9'(cur_next);
        step.job_b = job;
        if (!in_fire)
            step = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            req_reg <= '0;
            esc_reg <= 1'b0;
            args_reg <= '0;
            cnt_reg <= '0;
            cur_reg <= '0;
            armed_reg <= 1'b0;
            tcount_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            req_reg <= req_next;
            esc_reg <= esc_next;
            args_reg <= args_next;
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
            armed_reg <= armed_next;
            tcount_reg <= tcount_next;
        end
    end

    property p_armed_in_cells;
        @(posedge clk) disable iff (!rst_n) armed_reg |-> phase_reg == PH_CELLS;
    endproperty
    assert property (p_armed_in_cells) else $error("timer armed outside a display packet");

    property p_phase_onehot;
        @(posedge clk) disable iff (!rst_n) $onehot(phase_reg);
    endproperty
    assert property (p_phase_onehot) else $error("parse phase not one-hot");

endmodule
`default_nettype wire

// ===== hdl/bepr_back.sv =====
// back end: step queue and sequencer that expands each step into result transfers
`default_nettype none
module bepr_back #(
    parameter int QDEPTH = bepr_pkg::STEP_QDEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bepr_pkg::step_t    step,
    output logic                    space,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bepr_pkg::out_item_t     out_item
);
    localparam int QW = $clog2(QDEPTH);

    bepr_pkg::step_t q_mem [QDEPTH];
    logic [QW-1:0] wp_reg, rp_reg;
    logic [QW:0]   n_reg, n_next;

    // sequencer position within the head step
    // stage: 0 job_a, 1 cell, 2 frame, 3 job_b
    logic [1:0] stg_reg, stg_next;
    logic [4:0] pos_reg, pos_next;
    logic       dup_reg, dup_next;
    logic       pop;
    logic       has_out;
    bepr_pkg::out_item_t cand;
    logic       done;

    bepr_pkg::out_item_t oreg_reg;
    logic       ovalid_reg;
    logic       take;

    bepr_pkg::step_t head;
    assign head = q_mem[rp_reg];
    assign space = (n_reg < (QW+1)'(QDEPTH - 1));

    function automatic logic [4:0] job_len(input logic [2:0] j);
        logic [4:0] r;
        case (j)
            bepr_pkg::JOB_COUNT:   r = 5'd2;
            bepr_pkg::JOB_VERSION: r = 5'd2;
            bepr_pkg::JOB_SERIAL:  r = 5'd9;
            bepr_pkg::JOB_IDENT:   r = 5'd17;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] job_byte(input logic [2:0] j, input logic [4:0] k,
                                            input bepr_pkg::step_t s);
        logic [7:0] r;
        r = 8'h00;
        case (j)
            bepr_pkg::JOB_COUNT:   r = (k == 5'd0) ? 8'h01 : s.cnt_byte;
            bepr_pkg::JOB_VERSION: r = (k == 5'd0) ? 8'h05 : 8'h01;
            bepr_pkg::JOB_SERIAL:  r = (k == 5'd0) ? 8'h8A : 8'h30;
            bepr_pkg::JOB_IDENT:   r = bepr_pkg::ident_byte(k, s.col_tens, s.col_ones);
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // find the next output of the head step from the current position
    always_comb
    begin
        logic [2:0] j;
        logic [1:0] st;
        logic [4:0] p;
        logic       d;
        logic [7:0] by;
        logic       found;
        logic       rest;
        j = bepr_pkg::JOB_NONE;
        st = stg_reg;
        p = pos_reg;
        d = dup_reg;
        by = 8'h00;
        found = 1'b0;
        cand = '0;
        // skip empty stages
        for (int i = 0; i < 4; i++)
        begin
            if (!found)
            begin
                case (st)
                    2'd0: j = head.job_a;
                    2'd3: j = head.job_b;
                    default: j = bepr_pkg::JOB_NONE;
                endcase
                if (st == 2'd0 || st == 2'd3)
                begin
                    if (j != bepr_pkg::JOB_NONE)
                        found = 1'b1;
                end
                else if (st == 2'd1)
                    found = head.cell_ev;
                else
                    found = head.frame_ev;
                if (!found && st != 2'd3)
                begin
                    st = st + 2'd1;
                    p = '0;
                    d = 1'b0;
                end
            end
        end
        has_out = found && (n_reg != '0);
        stg_next = st;
        pos_next = p;
        dup_next = d;
        done = 1'b0;
        if (st == 2'd1)
        begin
            cand.kind = bepr_pkg::KIND_CELL;
            cand.value = head.cell_val;
            cand.cell_index = head.cell_idx;
            stg_next = 2'd2;
        end
        else if (st == 2'd2)
        begin
            cand.kind = bepr_pkg::KIND_FRAME;
            cand.cursor_position = head.frame_cur;
            stg_next = 2'd3;
        end
        else
        begin
            cand.kind = bepr_pkg::KIND_REPLY;
            // position 0 is the leading escape, then payload bytes
            if (p == 5'd0)
            begin
                cand.value = bepr_pkg::ESC_BYTE;
                pos_next = 5'd1;
            end
            else
            begin
                by = job_byte(j, p - 5'd1, head);
                cand.value = by;
                if (by == bepr_pkg::ESC_BYTE && !d)
                    dup_next = 1'b1;
                else
                begin
                    dup_next = 1'b0;
                    pos_next = p + 5'd1;
                end
            end
            if (pos_next == job_len(j) + 5'd1 && !dup_next)
            begin
                stg_next = st + 2'd1;
                pos_next = '0;
                if (st == 2'd3)
                    done = 1'b1;
            end
        end
        // is anything left after this one
        rest = 1'b0;
        if (!done)
        begin
            if (stg_next == 2'd1)
                rest = head.cell_ev || head.frame_ev || head.job_b != bepr_pkg::JOB_NONE;
            else if (stg_next == 2'd2)
                rest = head.frame_ev || head.job_b != bepr_pkg::JOB_NONE;
            else if (stg_next == 2'd3)
                rest = head.job_b != bepr_pkg::JOB_NONE;
            else
                rest = 1'b1;
        end
        if (st == 2'd3 && !done)
            rest = 1'b1;
        cand.last = !rest;
        if (!found)
            cand.last = 1'b1;
    end

    assign take = !ovalid_reg || out_ready;
    assign pop = (n_reg != '0) && take && (!has_out || cand.last);

    always_comb
    begin
        n_next = n_reg;
        if (push && !pop)
            n_next = n_reg + (QW+1)'(1);
        else if (!push && pop)
            n_next = n_reg - (QW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= step;
        if (take && has_out)
            oreg_reg <= cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
            stg_reg <= '0;
            pos_reg <= '0;
            dup_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == QW'(QDEPTH - 1)) ? '0 : wp_reg + QW'(1);
            n_reg <= n_next;
            if (take)
                ovalid_reg <= has_out;
            if (pop)
            begin
                rp_reg <= (rp_reg == QW'(QDEPTH - 1)) ? '0 : rp_reg + QW'(1);
                stg_reg <= '0;
                pos_reg <= '0;
                dup_reg <= 1'b0;
            end
            else if (take && has_out)
            begin
                stg_reg <= stg_next;
                pos_reg <= pos_next;
                dup_reg <= dup_next;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_item = oreg_reg;

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) push |-> n_reg < (QW+1)'(QDEPTH);
    endproperty
    assert property (p_no_overflow) else $error("step queue overflow");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) n_reg <= (QW+1)'(QDEPTH);
    endproperty
    assert property (p_count_bound) else $error("queue count out of range");

    property p_hold;
        @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> $stable(oreg_reg);
    endproperty
    assert property (p_hold) else $error("output register changed while stalled");

endmodule
`default_nettype wire
